// ===== hw/rtl/tmp_pkg.sv =====
// shared types and constants for the trapezoidal motion profile block
package tmp_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned VEL_W     = 25;
  localparam int unsigned SPD_W     = 24;
  localparam int unsigned TICK_BITS = 24;
  localparam int unsigned DUR_W     = 40;
  localparam int unsigned DUR_FRAC  = 16;
  localparam int unsigned MUL_XW    = 48;
  localparam int unsigned MUL_PW    = 72;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned ROOT_W    = 32;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_GO   = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  localparam logic REG_MAX_SPEED  = 1'b0;
  localparam logic REG_ACCEL_RATE = 1'b1;

  localparam logic [SPD_W-1:0] MAX_SPEED_RST  = 24'd109227;
  localparam logic [SPD_W-1:0] ACCEL_RATE_RST = 24'd910;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_GO_LATCH,
    CMD_MUL_DA,
    CMD_MUL_VV_CAP,
    CMD_TRI_TEST,
    CMD_DIV_DA,
    CMD_DIV_DV,
    CMD_SQRT,
    CMD_DUR_TRI,
    CMD_DIV_VA_CAP,
    CMD_DUR_TRAP,
    CMD_GO_COMMIT,
    CMD_TICK_INC,
    CMD_TICK_END,
    CMD_DIV_AT,
    CMD_CAP_AT,
    CMD_MUL_TA,
    CMD_MUL_TT_CAP,
    CMD_MUL_PA,
    CMD_TRAV_ACC,
    CMD_MUL_VV,
    CMD_DIV_HR,
    CMD_MUL_TV_CAP,
    CMD_TRAV_CR,
    CMD_MUL_RA,
    CMD_MUL_RS_CAP,
    CMD_TRAV_DEC,
    CMD_TICK_OUT
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic busy;
    logic eq_pos;
    logic at_end;
    logic tri_move;
    logic ph_acc;
    logic ph_cruise;
  } dp_stat_t;

endpackage

// ===== hw/rtl/tmp_mul.sv =====
// shared 24x24 multiplier, 48-bit operand taken in two halves, low half first
module tmp_mul import tmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_XW-1:0] x,
  input  logic [SPD_W-1:0]  y,
  output logic              done,
  output logic [MUL_PW-1:0] prod
);

  logic [MUL_XW-1:0] x_r;
  logic [SPD_W-1:0]  y_r;
  logic [2:0]        ph_r;
  logic              done_r;
  logic [MUL_XW-1:0] mp_r;
  logic [MUL_PW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= {ph_r[1:0], start};
      done_r <= ph_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
    end
    if (ph_r[0]) begin
      mp_r <= x_r[SPD_W-1:0] * y_r;
    end
    if (ph_r[1]) begin
      acc_r <= {{(MUL_PW-MUL_XW){1'b0}}, mp_r};
      mp_r  <= x_r[MUL_XW-1:SPD_W] * y_r;
    end
    if (ph_r[2]) begin
      acc_r <= acc_r + {mp_r, {SPD_W{1'b0}}};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/tmp_div.sv =====
// restoring divider, one quotient bit per cycle
module tmp_div import tmp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     num,
  input  logic [DIV_CNT_W-1:0] steps,
  input  logic [SPD_W:0]       den,
  output logic                 done,
  output logic [DIV_W-1:0]     quo
);

  logic [DIV_W-1:0]     quo_r;
  logic [SPD_W:0]       rem_r;
  logic [SPD_W:0]       den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [SPD_W+1:0]     sh;
  logic [SPD_W+1:0]     diff;
  logic                 ge;

  // numerator arrives left aligned so that the quotient ends in the low bits
  assign sh   = {rem_r, quo_r[DIV_W-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= steps;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[SPD_W:0] : sh[SPD_W:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hw/rtl/tmp_sqrt.sv =====
// integer square root, two radicand bits per cycle
module tmp_sqrt import tmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [DIV_W-1:0]  x_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [5:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [ROOT_W+3:0] rs;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;
  logic              ge;

  assign rs    = {rem_r, x_r[DIV_W-1:DIV_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = rs >= trial;
  assign diff  = rs - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'(ROOT_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      x_r    <= {x_r[DIV_W-3:0], 2'b00};
      rem_r  <= ge ? diff[ROOT_W+1:0] : rs[ROOT_W+1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/tmp_dpath.sv =====
// motion state, scratch registers and the shared arithmetic units
module tmp_dpath import tmp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic signed [POS_W-1:0] in_value,
  input  logic [SPD_W-1:0]        max_speed,
  input  logic [SPD_W-1:0]        accel_rate,
  output dp_stat_t                stat,
  output logic signed [POS_W-1:0] position,
  output logic signed [VEL_W-1:0] velocity,
  output logic                    moving
);

  logic signed [POS_W-1:0] pos_r, start_r, goal_r, tgt_r;
  logic signed [VEL_W-1:0] vel_r;
  logic [TICK_BITS-1:0]    elapsed_r;
  logic [DUR_W-1:0]        dur_r, at_r;
  logic                    dir_r, busy_r, tri_r;
  logic [POS_W-1:0]        d_r, trav_r;
  logic [DIV_W-1:0]        pa_r;
  logic [MUL_XW-1:0]       pb_r;
  logic [SPD_W-1:0]        spd_r;

  logic [SPD_W-1:0]        v, a;
  logic signed [POS_W:0]   diff_in, diff_gs;
  logic [POS_W:0]          neg_in, neg_gs;
  logic [POS_W-1:0]        d_in, d_gs;
  logic [DUR_W-1:0]        tq, rem;
  logic                    short_move;
  logic [MUL_XW-1:0]       t_ext;

  logic                    mul_go, div_go, sqrt_go;
  logic [MUL_XW-1:0]       mul_x;
  logic [SPD_W-1:0]        mul_y;
  logic                    mul_done, div_done, sqrt_done;
  logic [MUL_PW-1:0]       mul_p;
  logic [DIV_W-1:0]        div_num, div_q;
  logic [DIV_CNT_W-1:0]    div_n;
  logic [SPD_W:0]          div_den;
  logic [ROOT_W-1:0]       sqrt_root;

  logic [MUL_XW-1:0]       spd_dec_w, spd_acc_w, run_w, run_net;
  logic [SPD_W-1:0]        spd_dec, spd_acc;
  logic [MUL_PW-2:0]       trav_half;
  logic [MUL_XW-2:0]       sub_w;
  logic [MUL_XW:0]         dur_sum;
  logic [VEL_W-1:0]        spd_ext;

  // zero rate acts as one
  assign v = (max_speed == '0) ? SPD_W'(1) : max_speed;
  assign a = (accel_rate == '0) ? SPD_W'(1) : accel_rate;

  assign diff_in = {in_value[POS_W-1], in_value} - {pos_r[POS_W-1], pos_r};
  assign neg_in  = -diff_in;
  assign d_in    = diff_in[POS_W] ? neg_in[POS_W-1:0] : diff_in[POS_W-1:0];
  assign diff_gs = {goal_r[POS_W-1], goal_r} - {start_r[POS_W-1], start_r};
  assign neg_gs  = -diff_gs;
  assign d_gs    = diff_gs[POS_W] ? neg_gs[POS_W-1:0] : diff_gs[POS_W-1:0];

  assign tq         = {elapsed_r, {DUR_FRAC{1'b0}}};
  assign rem        = dur_r - tq;
  assign t_ext      = {{(MUL_XW-TICK_BITS){1'b0}}, elapsed_r};
  assign short_move = {1'b0, dur_r} < {at_r, 1'b0};

  assign spd_acc_w = mul_p[MUL_XW-1:0];
  assign spd_acc   = (spd_acc_w > {{(MUL_XW-SPD_W){1'b0}}, v}) ? v : spd_acc_w[SPD_W-1:0];
  assign spd_dec_w = mul_p[DIV_W-1:DUR_FRAC];
  assign spd_dec   = (spd_dec_w > {{(MUL_XW-SPD_W){1'b0}}, v}) ? v : spd_dec_w[SPD_W-1:0];
  assign trav_half = mul_p[MUL_PW-1:1];
  assign sub_w     = mul_p[DIV_W-1:DUR_FRAC+1];
  assign run_w     = mul_p[MUL_XW-1:0];
  assign run_net   = (run_w > pb_r) ? run_w - pb_r : '0;
  assign dur_sum   = {1'b0, pa_r[MUL_XW-1:0]} + {{(MUL_XW+1-DUR_W){1'b0}}, div_q[DUR_W-1:0]};
  assign spd_ext   = {1'b0, spd_r};

  always_comb begin
    mul_go  = 1'b0;
    mul_x   = '0;
    mul_y   = '0;
    div_go  = 1'b0;
    div_num = '0;
    div_n   = '0;
    div_den = '0;
    sqrt_go = 1'b0;
    unique case (cmd)
      CMD_MUL_DA: begin
        mul_go = 1'b1;
        mul_x  = {{(MUL_XW-POS_W){1'b0}}, d_r};
        mul_y  = a;
      end
      CMD_MUL_VV_CAP, CMD_MUL_VV: begin
        mul_go = 1'b1;
        mul_x  = {{(MUL_XW-SPD_W){1'b0}}, v};
        mul_y  = v;
      end
      CMD_MUL_TA: begin
        mul_go = 1'b1;
        mul_x  = t_ext;
        mul_y  = a;
      end
      CMD_MUL_TT_CAP: begin
        mul_go = 1'b1;
        mul_x  = t_ext;
        mul_y  = elapsed_r;
      end
      CMD_MUL_PA: begin
        mul_go = 1'b1;
        mul_x  = mul_p[MUL_XW-1:0];
        mul_y  = a;
      end
      CMD_MUL_TV_CAP: begin
        mul_go = 1'b1;
        mul_x  = t_ext;
        mul_y  = v;
      end
      CMD_MUL_RA: begin
        mul_go = 1'b1;
        mul_x  = {{(MUL_XW-DUR_W){1'b0}}, rem};
        mul_y  = a;
      end
      CMD_MUL_RS_CAP: begin
        mul_go = 1'b1;
        mul_x  = {{(MUL_XW-DUR_W){1'b0}}, rem};
        mul_y  = spd_dec;
      end
      // d << 32 over a, 64 quotient bits
      CMD_DIV_DA: begin
        div_go  = 1'b1;
        div_num = {d_r, {(DIV_W-POS_W){1'b0}}};
        div_n   = DIV_CNT_W'(64);
        div_den = {1'b0, a};
      end
      // d << 16 over v, aligned to the top
      CMD_DIV_DV: begin
        div_go  = 1'b1;
        div_num = {d_r, {(DIV_W-POS_W){1'b0}}};
        div_n   = DIV_CNT_W'(48);
        div_den = {1'b0, v};
      end
      // ramp time v << 16 over a
      CMD_DIV_VA_CAP, CMD_DIV_AT: begin
        div_go  = 1'b1;
        div_num = {v, {(DIV_W-SPD_W){1'b0}}};
        div_n   = DIV_CNT_W'(40);
        div_den = {1'b0, a};
      end
      // half ramp distance v*v over 2a
      CMD_DIV_HR: begin
        div_go  = 1'b1;
        div_num = {mul_p[MUL_XW-1:0], {(DIV_W-MUL_XW){1'b0}}};
        div_n   = DIV_CNT_W'(48);
        div_den = {a, 1'b0};
      end
      CMD_SQRT: sqrt_go = 1'b1;
      default: ;
    endcase
  end

  tmp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_p)
  );

  tmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .steps (div_n),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  tmp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_go),
    .x     (div_q),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      vel_r     <= '0;
      start_r   <= '0;
      goal_r    <= '0;
      elapsed_r <= '0;
      dur_r     <= '0;
      dir_r     <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_LOAD: begin
          pos_r  <= in_value;
          vel_r  <= '0;
          busy_r <= 1'b0;
        end
        CMD_DUR_TRI: dur_r <= {{(DUR_W-ROOT_W-1){1'b0}}, sqrt_root, 1'b0};
        CMD_DUR_TRAP: dur_r <= (dur_sum[MUL_XW:DUR_W] != '0) ? '1 : dur_sum[DUR_W-1:0];
        CMD_GO_COMMIT: begin
          start_r   <= pos_r;
          goal_r    <= tgt_r;
          dir_r     <= tgt_r < pos_r;
          elapsed_r <= '0;
          busy_r    <= 1'b1;
        end
        CMD_TICK_INC: begin
          if (elapsed_r != '1) elapsed_r <= elapsed_r + 1'b1;
        end
        CMD_TICK_END: begin
          vel_r  <= '0;
          pos_r  <= goal_r;
          busy_r <= 1'b0;
        end
        CMD_TICK_OUT: begin
          vel_r <= dir_r ? -spd_ext : spd_ext;
          pos_r <= dir_r ? start_r - $signed(trav_r) : start_r + $signed(trav_r);
        end
        default: ;
      endcase
    end
  end

  // scratch registers for the go and tick sequences
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_GO_LATCH: begin
        tgt_r <= in_value;
        d_r   <= d_in;
      end
      CMD_MUL_VV_CAP: pa_r <= mul_p[DIV_W-1:0];
      CMD_TRI_TEST:   tri_r <= pa_r < mul_p[DIV_W-1:0];
      CMD_DIV_VA_CAP: pa_r <= div_q;
      CMD_TICK_INC:   d_r <= d_gs;
      CMD_CAP_AT:     at_r <= div_q[DUR_W-1:0];
      CMD_MUL_TT_CAP: spd_r <= spd_acc;
      CMD_TRAV_ACC: begin
        trav_r <= (trav_half > {{(MUL_PW-1-POS_W){1'b0}}, d_r}) ?
                  d_r : trav_half[POS_W-1:0];
      end
      CMD_MUL_TV_CAP: pb_r <= div_q[MUL_XW-1:0];
      CMD_TRAV_CR: begin
        spd_r  <= v;
        trav_r <= (run_net > {{(MUL_XW-POS_W){1'b0}}, d_r}) ? d_r : run_net[POS_W-1:0];
      end
      CMD_MUL_RS_CAP: spd_r <= spd_dec;
      CMD_TRAV_DEC: begin
        trav_r <= (sub_w >= {{(MUL_XW-1-POS_W){1'b0}}, d_r}) ?
                  '0 : d_r - sub_w[POS_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.unit_done = mul_done | div_done | sqrt_done;
    stat.busy      = busy_r;
    stat.eq_pos    = in_value == pos_r;
    stat.at_end    = dur_r <= tq;
    stat.tri_move  = tri_r;
    stat.ph_acc    = short_move ? ({tq, 1'b0} < {1'b0, dur_r}) : (tq < at_r);
    stat.ph_cruise = !short_move && (tq < dur_r - at_r);
  end

  assign position = pos_r;
  assign velocity = vel_r;
  assign moving   = busy_r;

endmodule

// ===== hw/rtl/tmp_ctrl.sv =====
// sequencer for go, tick and load items
module tmp_ctrl import tmp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] mode,
  input  dp_stat_t   stat,
  input  logic       out_free,
  output logic       in_ready,
  output cmd_t       cmd,
  output logic       out_load
);

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001,
    S_G1   = 24'h000002,
    S_G2   = 24'h000004,
    S_G3   = 24'h000008,
    S_G4   = 24'h000010,
    S_G5   = 24'h000020,
    S_G6   = 24'h000040,
    S_G7   = 24'h000080,
    S_G8   = 24'h000100,
    S_GC   = 24'h000200,
    S_T1   = 24'h000400,
    S_T2   = 24'h000800,
    S_T3   = 24'h001000,
    S_TA2  = 24'h002000,
    S_TA3  = 24'h004000,
    S_TA4  = 24'h008000,
    S_TC2  = 24'h010000,
    S_TC3  = 24'h020000,
    S_TC4  = 24'h040000,
    S_TD2  = 24'h080000,
    S_TD3  = 24'h100000,
    S_TOUT = 24'h200000,
    S_FIN  = 24'h400000,
    S_WAIT = 24'h800000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_FIN;
          unique case (mode)
            MODE_TICK: begin
              if (stat.busy) begin
                cmd       = CMD_TICK_INC;
                state_nxt = S_T1;
              end
            end
            MODE_GO: begin
              if (!stat.eq_pos) begin
                cmd       = CMD_GO_LATCH;
                state_nxt = S_G1;
              end
            end
            MODE_LOAD: cmd = CMD_LOAD;
            default: ;
          endcase
        end
      end
      S_G1: begin
        cmd = CMD_MUL_DA; state_nxt = S_WAIT; ret_nxt = S_G2;
      end
      S_G2: begin
        cmd = CMD_MUL_VV_CAP; state_nxt = S_WAIT; ret_nxt = S_G3;
      end
      S_G3: begin
        cmd = CMD_TRI_TEST; state_nxt = S_G4;
      end
      S_G4: begin
        state_nxt = S_WAIT;
        if (stat.tri_move) begin
          cmd = CMD_DIV_DA; ret_nxt = S_G5;
        end else begin
          cmd = CMD_DIV_DV; ret_nxt = S_G6;
        end
      end
      S_G5: begin
        cmd = CMD_SQRT; state_nxt = S_WAIT; ret_nxt = S_G7;
      end
      S_G7: begin
        cmd = CMD_DUR_TRI; state_nxt = S_GC;
      end
      S_G6: begin
        cmd = CMD_DIV_VA_CAP; state_nxt = S_WAIT; ret_nxt = S_G8;
      end
      S_G8: begin
        cmd = CMD_DUR_TRAP; state_nxt = S_GC;
      end
      S_GC: begin
        cmd = CMD_GO_COMMIT; state_nxt = S_FIN;
      end
      S_T1: begin
        if (stat.at_end) begin
          cmd = CMD_TICK_END; state_nxt = S_FIN;
        end else begin
          cmd = CMD_DIV_AT; state_nxt = S_WAIT; ret_nxt = S_T2;
        end
      end
      S_T2: begin
        cmd = CMD_CAP_AT; state_nxt = S_T3;
      end
      S_T3: begin
        state_nxt = S_WAIT;
        priority if (stat.ph_acc) begin
          cmd = CMD_MUL_TA; ret_nxt = S_TA2;
        end else if (stat.ph_cruise) begin
          cmd = CMD_MUL_VV; ret_nxt = S_TC2;
        end else begin
          cmd = CMD_MUL_RA; ret_nxt = S_TD2;
        end
      end
      S_TA2: begin
        cmd = CMD_MUL_TT_CAP; state_nxt = S_WAIT; ret_nxt = S_TA3;
      end
      S_TA3: begin
        cmd = CMD_MUL_PA; state_nxt = S_WAIT; ret_nxt = S_TA4;
      end
      S_TA4: begin
        cmd = CMD_TRAV_ACC; state_nxt = S_TOUT;
      end
      S_TC2: begin
        cmd = CMD_DIV_HR; state_nxt = S_WAIT; ret_nxt = S_TC3;
      end
      S_TC3: begin
        cmd = CMD_MUL_TV_CAP; state_nxt = S_WAIT; ret_nxt = S_TC4;
      end
      S_TC4: begin
        cmd = CMD_TRAV_CR; state_nxt = S_TOUT;
      end
      S_TD2: begin
        cmd = CMD_MUL_RS_CAP; state_nxt = S_WAIT; ret_nxt = S_TD3;
      end
      S_TD3: begin
        cmd = CMD_TRAV_DEC; state_nxt = S_TOUT;
      end
      S_TOUT: begin
        cmd = CMD_TICK_OUT; state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: begin
        if (stat.unit_done) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/trapezoidal_motion_profile.sv =====
// top level: stream ports, register port, result register and sequencer/datapath
// go items run two divides for a trapezoid, or a divide then a square root for a triangle
// one item at a time, next item taken the cycle after the load; rst_n is synchronous
module trapezoidal_motion_profile import tmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: value[31:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: position[31:0], velocity[56:32], moving[57], zero[63:58]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SPD_W-1:0]        max_speed_r;
  logic [SPD_W-1:0]        accel_rate_r;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic signed [VEL_W-1:0] out_vel_r;
  logic                    out_mov_r;

  cmd_t                    cmd;
  dp_stat_t                stat;
  logic                    out_load;
  logic                    out_free;
  logic signed [POS_W-1:0] dp_pos;
  logic signed [VEL_W-1:0] dp_vel;
  logic                    dp_mov;
  logic                    cfg_wr;
  logic                    in_fire;

  // register port: word select on paddr[2], never stalls
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= MAX_SPEED_RST;
      accel_rate_r <= ACCEL_RATE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_SPEED:  max_speed_r  <= pwdata[SPD_W-1:0];
        REG_ACCEL_RATE: accel_rate_r <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_SPEED:  prdata = {8'b0, max_speed_r};
      REG_ACCEL_RATE: prdata = {8'b0, accel_rate_r};
      default:        prdata = '0;
    endcase
  end

  // result register decouples the sequencer from the output handshake
  assign out_free = !out_valid_r || out_tready;
  assign in_fire  = in_tvalid && in_tready;

  tmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .mode     (in_tuser),
    .stat     (stat),
    .out_free (out_free),
    .in_ready (in_tready),
    .cmd      (cmd),
    .out_load (out_load)
  );

  tmp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_tdata),
    .max_speed  (max_speed_r),
    .accel_rate (accel_rate_r),
    .stat       (stat),
    .position   (dp_pos),
    .velocity   (dp_vel),
    .moving     (dp_mov)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r <= dp_pos;
      out_vel_r <= dp_vel;
      out_mov_r <= dp_mov;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_mov_r, out_vel_r, out_pos_r};

  // an accepted item keeps the input closed until its result is loaded
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input stayed open after an item was taken");

  // a stopped profile never reports a speed
  a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[57] |-> out_tdata[56:32] == '0)
    else $error("nonzero velocity while not moving");

  // after a result is loaded the sequencer is back to taking items
  a_load_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> in_tready)
    else $error("sequencer did not return to idle after a result");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the trapezoidal motion profile block
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmp_pkg::*;

  localparam longint unsigned TICK_MAX  = (64'd1 << TICK_BITS) - 1;
  localparam longint unsigned DUR_SAT   = (64'd1 << DUR_W) - 1;
  localparam longint unsigned U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int              CYCLE_CAP = 3000000;
  localparam int              TAIL_WAIT = 200;
  localparam int              RAND_ITEMS = 1100;

  // one result item as the block should give it
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [VEL_W-1:0] velocity;
    logic             moving;
  } motion_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = MODE_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  trapezoidal_motion_profile uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the block's registers and move state
  longint unsigned speed_reg = MAX_SPEED_RST;
  longint unsigned accel_reg = ACCEL_RATE_RST;
  longint          cur_pos, cur_vel, origin_pos, goal_pos;
  longint unsigned ticks_done, dur_q16;
  bit              heading_neg, in_motion;

  motion_out_t expected_q[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  function automatic longint unsigned nonzero(longint unsigned r);
    return (r == 0) ? 64'd1 : r;
  endfunction

  // saturating 64-bit product
  function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b);
    if (a != 0 && b > U64_MAX / a) return U64_MAX;
    return a * b;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic void profile_reset();
    cur_pos = 0; cur_vel = 0; origin_pos = 0; goal_pos = 0;
    ticks_done = 0; dur_q16 = 0; heading_neg = 0; in_motion = 0;
  endfunction

  // work out duration of a new move (triangle: root, trapezoid: divides)
  function automatic void start_move(longint target);
    longint unsigned v, a, d, dur, q;
    longint diff;
    v = nonzero(speed_reg);
    a = nonzero(accel_reg);
    diff = target - cur_pos;
    d = (diff < 0) ? -diff : diff;
    if (d * a < v * v) begin
      q = ((d / a) << 32) + (((d % a) << 32) / a);
      dur = 2 * int_sqrt(q);
    end else begin
      dur = ((d << DUR_FRAC) / v) + ((v << DUR_FRAC) / a);
    end
    dur_q16 = (dur > DUR_SAT) ? DUR_SAT : dur;
    origin_pos = cur_pos;
    goal_pos = target;
    heading_neg = target < cur_pos;
    ticks_done = 0;
    in_motion = 1;
  endfunction

  // one tick of an active move
  function automatic void advance_tick();
    longint unsigned v, a, t, tq, at, dur, d, trav, spd, half_ramp, run, rem, sub;
    longint diff;
    v = nonzero(speed_reg);
    a = nonzero(accel_reg);
    if (ticks_done < TICK_MAX) ticks_done++;
    t = ticks_done;
    tq = t << DUR_FRAC;
    dur = dur_q16;
    if (dur <= tq) begin
      // end of move: snap to goal
      cur_vel = 0;
      cur_pos = goal_pos;
      in_motion = 0;
      return;
    end
    at = (v << DUR_FRAC) / a;
    diff = goal_pos - origin_pos;
    d = (diff < 0) ? -diff : diff;
    if ((dur < 2 * at) ? (2 * tq < dur) : (tq < at)) begin
      spd = sat_mul(t, a);
      trav = sat_mul(sat_mul(t, t), a) / 2;
    end else if (dur >= 2 * at && tq < dur - at) begin
      half_ramp = (v * v) / (2 * a);
      run = t * v;
      spd = v;
      trav = (run > half_ramp) ? run - half_ramp : 0;
    end else begin
      rem = dur - tq;
      spd = sat_mul(rem, a) >> DUR_FRAC;
      if (spd > v) spd = v;
      sub = sat_mul(rem, spd) >> (DUR_FRAC + 1);
      trav = (sub >= d) ? 0 : d - sub;
    end
    if (spd > v) spd = v;
    if (trav > d) trav = d;
    cur_vel = heading_neg ? -longint'(spd) : longint'(spd);
    cur_pos = heading_neg ? origin_pos - longint'(trav) : origin_pos + longint'(trav);
  endfunction

  function automatic motion_out_t predict_motion(logic [1:0] mode, logic [31:0] value);
    motion_out_t r;
    longint val;
    val = longint'($signed(value));
    if (mode == MODE_TICK) begin
      if (in_motion) advance_tick();
    end else if (mode == MODE_GO) begin
      if (val != cur_pos) start_move(val);
    end else if (mode == MODE_LOAD) begin
      cur_pos = val;
      cur_vel = 0;
      in_motion = 0;
    end
    r.position = cur_pos[POS_W-1:0];
    r.velocity = cur_vel[VEL_W-1:0];
    r.moving   = in_motion;
    return r;
  endfunction

  // send one item, with an optional random gap first
  task automatic send_item(logic [1:0] mode, logic [31:0] value);
    bit rdy;
    // step off the edge at which the previous item dropped tvalid
    @(posedge clk);
    if (!no_idle && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 15)) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    expected_q.push_back(predict_motion(mode, value));
    items_sent++;
    in_tvalid <= 1'b0;
  endtask

  // block is idle once every expected result is back and the latency has passed
  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAX_SPEED) speed_reg = data[SPD_W-1:0];
    else accel_reg = data[SPD_W-1:0];
  endtask

  task automatic set_profile(logic [31:0] v, logic [31:0] a);
    wait_drained();
    write_reg(REG_MAX_SPEED, v);
    write_reg(REG_ACCEL_RATE, a);
  endtask

  // tick until the move ends or the cap is hit
  task automatic run_ticks(int cap);
    for (int i = 0; i < cap && in_motion; i++) send_item(MODE_TICK, $urandom);
  endtask

  // every mode, idle cases, restart and load during a move
  task automatic test_modes();
    send_item(MODE_TICK, 32'h0);              // tick while idle
    send_item(MODE_GO, 32'h0);                // go to where it already is
    send_item(2'd3, 32'hDEAD_BEEF);           // unused mode
    send_item(MODE_LOAD, 32'h7FFF_FFFF);
    send_item(MODE_LOAD, 32'h8000_0000);
    send_item(MODE_LOAD, 32'h0000_0000);
    send_item(MODE_GO, 32'h0003_0000);        // short move, triangle
    run_ticks(8);
    send_item(MODE_GO, 32'hFFF0_0000);        // restart while moving
    send_item(MODE_TICK, 32'h0);
    send_item(MODE_LOAD, 32'h0001_0000);      // load stops the move
    send_item(MODE_TICK, 32'h0);
  endtask

  // register extremes, zero registers and saturating long moves
  task automatic test_config_extremes();
    set_profile(32'h00FF_FFFF, 32'h00FF_FFFF);
    send_item(MODE_LOAD, 32'h8000_0000);
    send_item(MODE_GO, 32'h7FFF_FFFF);
    run_ticks(6);
    set_profile(32'h0000_0000, 32'h0000_0000);   // zero acts as one
    send_item(MODE_LOAD, 32'h8000_0000);
    send_item(MODE_GO, 32'h7FFF_FFFF);           // duration saturates
    run_ticks(3);
    set_profile(32'hFF00_0001, 32'h00FF_FFFF);   // upper bits ignored
    send_item(MODE_LOAD, 32'h0);
    send_item(MODE_GO, 32'h0000_0040);
    run_ticks(4);
    send_item(MODE_GO, 32'h0010_0000);
    run_ticks(4);
  endtask

  // random profiles and well formed moves with random interruptions
  task automatic test_random_moves();
    logic [31:0] v, a, target;
    int          pick;
    while (items_sent < RAND_ITEMS) begin
      if (items_sent > RAND_ITEMS - 120) no_idle = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom_range(32'h0000_4000, 32'h0010_0000);
        a = v / $urandom_range(1, 20) + 1;
        if ($urandom_range(0, 7) == 0) v = $urandom;
        set_profile(v, a);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(MODE_LOAD, $urandom);
      end else if (pick == 1) begin
        send_item(2'($urandom_range(0, 3)), $urandom);   // noise
      end else begin
        target = cur_pos[31:0] + (($urandom_range(0, 1) ? 1 : -1) *
                 int'($urandom_range(1, 40) * nonzero(speed_reg)));
        if ($urandom_range(0, 15) == 0) target = $urandom;
        send_item(MODE_GO, target);
        run_ticks($urandom_range(0, 7) == 0 ? $urandom_range(1, 20) : 120);
      end
    end
  endtask

  // sender holds off until every result is back, then carries on
  task automatic test_drain_pause();
    send_item(MODE_LOAD, 32'h0000_1234);
    send_item(MODE_GO, 32'h0020_0000);
    run_ticks(5);
    while (expected_q.size() != 0) @(posedge clk);
    run_ticks(200);
    if (in_motion) send_item(MODE_LOAD, 32'h0);
  endtask

  // result receiver with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result at the negedge before the edge that takes it
  always @(negedge clk) begin
    motion_out_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.position = out_tdata[31:0];
      got.velocity = out_tdata[56:32];
      got.moving   = out_tdata[57];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.position !== want.position) begin
          $display("%0t: position expected %h actual %h", $time, want.position, got.position);
          err_count++;
        end
        if (got.velocity !== want.velocity) begin
          $display("%0t: velocity expected %h actual %h", $time, want.velocity, got.velocity);
          err_count++;
        end
        if (got.moving !== want.moving) begin
          $display("%0t: moving expected %b actual %b", $time, want.moving, got.moving);
          err_count++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    profile_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_modes();
    test_config_extremes();
    test_drain_pause();
    test_random_moves();
    wait_drained();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
